FILE: rtl/slfr_pkg.sv
// Package for the sync-and-length frame receiver and record decoder.
// Holds the shared types, frame layout positions, module codes and record kind codes.
// No dependencies.
package slfr_pkg;

    localparam int KEPT_BYTES = 19;
    localparam int KIDX_W     = 5;
    localparam int FLEN_W     = 9;
    localparam int CNT_W      = 3;

    typedef logic [7:0]                  t_byte;
    typedef logic [KEPT_BYTES-1:0][7:0]  t_frame_bytes;
    typedef logic [2:0]                  t_kind;

    // Header bytes and frame length rule.
    localparam t_byte             HDR0       = 8'h55;
    localparam t_byte             HDR1       = 8'hAA;
    localparam logic [FLEN_W-1:0] LEN_OFFSET = 9'd8;
    localparam logic [FLEN_W-1:0] FLEN_RESET = 9'd14;

    // Frame positions.
    localparam int POS_LEN    = 3;
    localparam int POS_MODULE = 4;
    localparam int POS_SUB    = 6;
    localparam int POS_SEL    = 8;

    // Module byte codes.
    localparam t_byte MOD_IO     = 8'h06;
    localparam t_byte MOD_ANALOG = 8'h07;
    localparam t_byte MOD_MOTOR  = 8'h08;
    localparam t_byte MOD_IMU    = 8'h09;
    localparam t_byte MOD_SOUND  = 8'h0a;

    // IMU sub-types.
    localparam t_byte IMU_GYRO   = 8'd1;
    localparam t_byte IMU_ACCEL  = 8'd2;
    localparam t_byte IMU_QUAT_A = 8'd3;
    localparam t_byte IMU_QUAT_B = 8'd4;

    // Record kinds.
    localparam t_kind KIND_IO      = 3'd0;
    localparam t_kind KIND_ANALOG  = 3'd1;
    localparam t_kind KIND_MOT_CUR = 3'd2;
    localparam t_kind KIND_MOT_POS = 3'd3;
    localparam t_kind KIND_GYRO    = 3'd4;
    localparam t_kind KIND_ACCEL   = 3'd5;
    localparam t_kind KIND_QUAT    = 3'd6;
    localparam t_kind KIND_SOUND   = 3'd7;

    // Completed frame handed from the receiver to the decoder.
    typedef struct packed {
        logic         done;
        t_frame_bytes bytes;
    } t_frame_evt;

endpackage

FILE: rtl/slfr_if.sv
// Valid/ready channel interfaces for received bytes and decoded records.
// Depends on nothing.
interface slfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfr_rec_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [3:0]         channel;
    logic signed [31:0] value;
    logic               first_quat;
    logic               last;

    modport source (output valid, output kind, output channel, output value,
                    output first_quat, output last, input ready);
    modport sink   (input valid, input kind, input channel, input value,
                    input first_quat, input last, output ready);
endinterface

FILE: rtl/slfr_rx.sv
// Frame receiver: header hunt, length tracking and the kept frame bytes.
// Depends on slfr_pkg and slfr_byte_if.
module slfr_rx #(
    parameter int BUFFER_LIMIT = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    slfr_byte_if.sink           i_byte,
    input  logic                i_dec_busy,
    output slfr_pkg::t_frame_evt o_evt
);

    localparam int IW = $clog2(BUFFER_LIMIT + 1);
    localparam int CW = (IW > slfr_pkg::FLEN_W) ? IW : slfr_pkg::FLEN_W;

    logic                          r_in_frame, n_in_frame;
    slfr_pkg::t_byte               r_prev, n_prev;
    logic [IW-1:0]                 r_idx, n_idx;
    logic [slfr_pkg::FLEN_W-1:0]   r_flen, n_flen;
    slfr_pkg::t_frame_bytes        r_bytes, n_bytes;
    logic                          n_done;
    logic                          will_complete;
    logic                          accept;
    logic [IW-1:0]                 idx_inc;
    slfr_pkg::t_byte               b;

    assign b       = i_byte.rx_byte;
    assign idx_inc = r_idx + IW'(1);

    // The length byte itself can never complete a frame, so the stall test
    // does not look at the incoming data.
    assign will_complete = r_in_frame && (r_idx != IW'(slfr_pkg::POS_LEN))
                           && (CW'(idx_inc) == CW'(r_flen));
    assign i_byte.ready  = !i_dec_busy || !will_complete;
    assign accept        = i_byte.valid && i_byte.ready;

    always_comb begin
        n_in_frame = r_in_frame;
        n_prev     = r_prev;
        n_idx      = r_idx;
        n_flen     = r_flen;
        n_bytes    = r_bytes;
        n_done     = 1'b0;
        if (accept) begin
            if (r_idx < IW'(slfr_pkg::KEPT_BYTES)) begin
                n_bytes[r_idx[slfr_pkg::KIDX_W-1:0]] = b;
            end
            if (!r_in_frame && r_prev == slfr_pkg::HDR0 && b == slfr_pkg::HDR1) begin
                n_in_frame = 1'b1;
                n_bytes[0] = slfr_pkg::HDR0;
                n_bytes[1] = slfr_pkg::HDR1;
                n_idx      = IW'(2);
                n_prev     = '0;
            end else if (r_in_frame) begin
                if (r_idx == IW'(slfr_pkg::POS_LEN)) begin
                    n_flen = {1'b0, b} + slfr_pkg::LEN_OFFSET;
                end
                n_idx = idx_inc;
                if (CW'(idx_inc) == CW'(n_flen)) begin
                    n_done     = 1'b1;
                    n_in_frame = 1'b0;
                end
                if (idx_inc >= IW'(BUFFER_LIMIT)) begin
                    n_in_frame = 1'b0;
                end
            end else begin
                n_prev = b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_prev     <= '0;
            r_idx      <= '0;
            r_flen     <= slfr_pkg::FLEN_RESET;
            r_bytes    <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_prev     <= n_prev;
            r_idx      <= n_idx;
            r_flen     <= n_flen;
            r_bytes    <= n_bytes;
        end
    end

    // The decoder takes the frame including the byte that completes it.
    assign o_evt.done  = n_done;
    assign o_evt.bytes = n_bytes;

endmodule

FILE: rtl/slfr_dec.sv
// Record decoder: frame snapshot, record sequencer and output register.
// Depends on slfr_pkg and slfr_rec_if.
module slfr_dec (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slfr_pkg::t_frame_evt i_evt,
    output logic                 o_busy,
    slfr_rec_if.source           o_rec
);

    logic [slfr_pkg::KEPT_BYTES-1:slfr_pkg::POS_MODULE][7:0] r_fb;
    logic [slfr_pkg::CNT_W-1:0] r_cnt, r_k;
    logic                       r_busy, r_fq, r_quat_seen;
    logic                       r_ovalid;
    slfr_pkg::t_kind            r_okind;
    logic [3:0]                 r_och;
    logic [31:0]                r_oval;
    logic                       r_ofq, r_olast;

    logic [slfr_pkg::CNT_W-1:0] cap_cnt;
    logic                       cap_quat_b;
    slfr_pkg::t_byte            cap_mod, cap_sel, cap_sub;
    slfr_pkg::t_kind            rec_kind;
    logic [3:0]                 rec_ch;
    logic [31:0]                rec_val;
    logic [slfr_pkg::CNT_W-1:0] k_inc;
    logic                       load;
    slfr_pkg::t_byte            mod, sel, sub;
    logic [3:0]                 grp_base;

    assign cap_mod = i_evt.bytes[slfr_pkg::POS_MODULE];
    assign cap_sel = i_evt.bytes[slfr_pkg::POS_SEL];
    assign cap_sub = i_evt.bytes[slfr_pkg::POS_SUB];

    // Number of records for the completed frame.
    always_comb begin
        cap_cnt    = '0;
        cap_quat_b = 1'b0;
        case (cap_mod)
            slfr_pkg::MOD_IO: cap_cnt = 3'd4;
            slfr_pkg::MOD_ANALOG: begin
                if (cap_sel >= 8'd1 && cap_sel <= 8'd3) cap_cnt = 3'd5;
            end
            slfr_pkg::MOD_MOTOR: begin
                if (cap_sel >= 8'd1 && cap_sel <= 8'd9) cap_cnt = 3'd2;
            end
            slfr_pkg::MOD_IMU: begin
                if (cap_sub == slfr_pkg::IMU_GYRO || cap_sub == slfr_pkg::IMU_ACCEL) begin
                    cap_cnt = 3'd3;
                end else if (cap_sub == slfr_pkg::IMU_QUAT_A) begin
                    cap_cnt = 3'd2;
                end else if (cap_sub == slfr_pkg::IMU_QUAT_B) begin
                    cap_cnt    = 3'd2;
                    cap_quat_b = 1'b1;
                end
            end
            slfr_pkg::MOD_SOUND: cap_cnt = 3'd1;
            default: cap_cnt = '0;
        endcase
    end

    assign mod = r_fb[slfr_pkg::POS_MODULE];
    assign sel = r_fb[slfr_pkg::POS_SEL];
    assign sub = r_fb[slfr_pkg::POS_SUB];

    always_comb begin
        unique case (sel[1:0])
            2'd2:    grp_base = 4'd5;
            2'd3:    grp_base = 4'd10;
            default: grp_base = 4'd0;
        endcase
    end

    // Record number r_k of the stored frame.
    always_comb begin
        rec_kind = slfr_pkg::KIND_IO;
        rec_ch   = {1'b0, r_k};
        rec_val  = '0;
        case (mod)
            slfr_pkg::MOD_IO: begin
                rec_kind = slfr_pkg::KIND_IO;
                rec_val  = {31'd0, sel[r_k[1:0]]};
            end
            slfr_pkg::MOD_ANALOG: begin
                rec_kind = slfr_pkg::KIND_ANALOG;
                rec_ch   = grp_base + {1'b0, r_k};
                case (r_k)
                    3'd0:    rec_val = {16'd0, r_fb[9],  r_fb[10]};
                    3'd1:    rec_val = {16'd0, r_fb[11], r_fb[12]};
                    3'd2:    rec_val = {16'd0, r_fb[13], r_fb[14]};
                    3'd3:    rec_val = {16'd0, r_fb[15], r_fb[16]};
                    default: rec_val = {16'd0, r_fb[17], r_fb[18]};
                endcase
            end
            slfr_pkg::MOD_MOTOR: begin
                rec_ch = sel[3:0] - 4'd1;
                if (r_k == '0) begin
                    rec_kind = slfr_pkg::KIND_MOT_CUR;
                    rec_val  = {r_fb[9], r_fb[10], r_fb[11], r_fb[12]};
                end else begin
                    rec_kind = slfr_pkg::KIND_MOT_POS;
                    rec_val  = {r_fb[13], r_fb[14], r_fb[15], r_fb[16]};
                end
            end
            slfr_pkg::MOD_IMU: begin
                if (sub == slfr_pkg::IMU_GYRO) begin
                    rec_kind = slfr_pkg::KIND_GYRO;
                end else if (sub == slfr_pkg::IMU_ACCEL) begin
                    rec_kind = slfr_pkg::KIND_ACCEL;
                end else begin
                    rec_kind = slfr_pkg::KIND_QUAT;
                end
                // The second quaternion frame carries the y and z components.
                if (sub == slfr_pkg::IMU_QUAT_B) rec_ch = {1'b0, r_k} + 4'd2;
                case (r_k)
                    3'd0:    rec_val = {r_fb[7],  r_fb[8],  r_fb[9],  r_fb[10]};
                    3'd1:    rec_val = {r_fb[11], r_fb[12], r_fb[13], r_fb[14]};
                    default: rec_val = {r_fb[15], r_fb[16], r_fb[17], r_fb[18]};
                endcase
            end
            slfr_pkg::MOD_SOUND: begin
                rec_kind = slfr_pkg::KIND_SOUND;
                rec_ch   = 4'd0;
                rec_val  = {16'd0, r_fb[8], r_fb[9]};
            end
            default: begin
                rec_kind = slfr_pkg::KIND_IO;
                rec_val  = '0;
            end
        endcase
    end

    assign k_inc = r_k + 3'd1;
    assign load  = r_busy && (!r_ovalid || o_rec.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_quat_seen <= 1'b0;
            r_ovalid    <= 1'b0;
            r_k         <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_evt.done) begin
                r_cnt  <= cap_cnt;
                r_k    <= '0;
                r_busy <= (cap_cnt != '0);
                if (cap_quat_b) r_quat_seen <= 1'b1;
            end else if (load) begin
                r_k <= k_inc;
                if (k_inc == r_cnt) r_busy <= 1'b0;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_rec.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.done) begin
            r_fb <= i_evt.bytes[slfr_pkg::KEPT_BYTES-1:slfr_pkg::POS_MODULE];
            r_fq <= cap_quat_b && !r_quat_seen;
        end
        if (load) begin
            r_okind <= rec_kind;
            r_och   <= rec_ch;
            r_oval  <= rec_val;
            r_ofq   <= r_fq;
            r_olast <= (k_inc == r_cnt);
        end
    end

    assign o_busy           = r_busy;
    assign o_rec.valid      = r_ovalid;
    assign o_rec.kind       = r_okind;
    assign o_rec.channel    = r_och;
    assign o_rec.value      = r_oval;
    assign o_rec.first_quat = r_ofq;
    assign o_rec.last       = r_olast;

endmodule

FILE: rtl/sync_length_frame_receiver_decoder_top.sv
// Sync-and-length frame receiver with record decoder, top level.
// Depends on slfr_pkg, slfr_if, slfr_rx and slfr_dec.
//
// Received bytes are taken one per clock cycle. The receiver hunts for the
// 0x55 0xAA header outside a frame, takes the total length from the fourth
// byte (value plus 8) and drops a frame that reaches BUFFER_LIMIT bytes
// without completing. The byte that completes a frame hands a snapshot of
// the first 19 frame bytes to the record sequencer, which puts out one
// record per cycle while the output is ready (one to five per frame, none
// for an unknown module, selector or sub-type) through an output register.
// Only a completing byte can stall: it waits while the sequencer is still
// sending the previous frame's records, which output back pressure can
// prolong. No checksum is checked.
module sync_length_frame_receiver_decoder_top #(
    parameter int BUFFER_LIMIT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slfr_byte_if.sink   i_in,
    slfr_rec_if.source  o_out
);

    slfr_pkg::t_frame_evt evt;
    logic                 dec_busy;

    slfr_rx #(
        .BUFFER_LIMIT(BUFFER_LIMIT)
    ) u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_in),
        .i_dec_busy(dec_busy),
        .o_evt     (evt)
    );

    slfr_dec u_dec (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_evt  (evt),
        .o_busy (dec_busy),
        .o_rec  (o_out)
    );

endmodule
